// ----- rtl/tile_palette_analyzer_macros.svh -----
// ----------------------------------------------------------------------------
// tile palette analyzer assertion macros
// shared property shorthands, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef TILE_PALETTE_ANALYZER_MACROS_SVH
`define TILE_PALETTE_ANALYZER_MACROS_SVH

// same-cycle implication
`define TPA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tile palette analyzer: property violated");

// next-cycle implication
`define TPA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tile palette analyzer: property violated");

`endif

// ----- rtl/tpa_pkg.sv -----
// ----------------------------------------------------------------------------
// tpa_pkg
// constants, codes and controller/datapath interface types of the analyzer
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int MAX_TILE      = 48;
  localparam int IDX_W         = $clog2(PALETTE_DEPTH);
  localparam int CNT_W         = $clog2(PALETTE_DEPTH + 1);
  localparam int PIX_W         = 32;
  localparam int SIDE_W        = 6;
  localparam int BPP_W         = 3;
  localparam int EST_W         = 14;

  localparam logic [7:0] CTL_RAW          = 8'h00;
  localparam logic [7:0] CTL_PACKED       = 8'h50;
  localparam logic [7:0] CTL_FULL_PALETTE = 8'h60;
  localparam logic [7:0] CTL_SOLID        = 8'h80;
  localparam logic [7:0] CTL_JPEG         = 8'h90;
  localparam logic [7:0] CTL_STREAM_RESET = 8'h0f;

  localparam logic [1:0] FILTER_NONE    = 2'd0;
  localparam logic [1:0] FILTER_PALETTE = 2'd1;

  localparam int JPEG_MIN_BYTES = 3000;
  localparam int JPEG_MIN_SIDE  = 16;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;
  localparam logic REG_BPP = 1'b0;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CHECK  = 6'b000010,
    S_SEARCH = 6'b000100,
    S_MATH1  = 6'b001000,
    S_MATH2  = 6'b010000,
    S_OUT    = 6'b100000
  } tpa_state_t;

  typedef struct packed {
    logic take;
    logic check;
    logic search;
    logic math1;
    logic math2;
    logic load;
  } tpa_cmd_t;

  typedef struct packed {
    logic need_search;
    logic hit;
    logic miss;
    logic last;
    logic out_free;
  } tpa_status_t;

endpackage

`default_nettype wire

// ----- rtl/tpa_ram.sv -----
// ----------------------------------------------------------------------------
// tpa_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/tpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// tpa_ctrl
// sequencer: take item, resolve palette index, size math, deliver result
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_ctrl import tpa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire tpa_status_t status,
  output tpa_cmd_t         cmd
);

  tpa_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (status.need_search) state_next = S_SEARCH;
        else if (status.last) state_next = S_MATH1;
        else state_next = S_OUT;
      end
      S_SEARCH: begin
        if (status.hit || status.miss) begin
          state_next = status.last ? S_MATH1 : S_OUT;
        end
      end
      S_MATH1: state_next = S_MATH2;
      S_MATH2: state_next = S_OUT;
      S_OUT: begin
        if (status.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready   = (state == S_IDLE);
  assign cmd.take   = in_valid && (state == S_IDLE);
  assign cmd.check  = (state == S_CHECK);
  assign cmd.search = (state == S_SEARCH);
  assign cmd.math1  = (state == S_MATH1);
  assign cmd.math2  = (state == S_MATH2);
  assign cmd.load   = (state == S_OUT) && status.out_free;

endmodule

`default_nettype wire

// ----- rtl/tpa_datapath.sv -----
// ----------------------------------------------------------------------------
// tpa_datapath
// palette store and search, tile state, size estimates and result register
// ----------------------------------------------------------------------------
`default_nettype none

`include "tile_palette_analyzer_macros.svh"

module tpa_datapath import tpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire tpa_cmd_t          cmd,
  output tpa_status_t            status,
  input  wire logic [BPP_W-1:0]  bpp_cfg,
  input  wire logic [PIX_W-1:0]  pixel,
  input  wire logic [SIDE_W-1:0] tile_width,
  input  wire logic [SIDE_W-1:0] tile_height,
  input  wire logic              last_pixel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       pixel_index,
  output logic                   new_color,
  output logic                   overflow,
  output logic                   tile_done,
  output logic [7:0]             control_byte,
  output logic [1:0]             filter_id,
  output logic [CNT_W-1:0]       color_count,
  output logic [EST_W-1:0]       est_size
);

  // captured item
  logic [PIX_W-1:0]  px;
  logic [SIDE_W-1:0] w;
  logic [SIDE_W-1:0] h;
  logic              last;
  logic [BPP_W-1:0]  bpp;

  // tile state
  logic [CNT_W-1:0] total;
  logic [PIX_W-1:0] prev_px;
  logic [IDX_W-1:0] prev_idx;
  logic             in_tile;
  logic             overflowed;
  logic             stream_pend;

  // search pipeline
  logic [CNT_W-1:0] rd_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic [PIX_W-1:0] ram_q;

  // per-item result
  logic [IDX_W-1:0] idx;
  logic             fresh;

  // size math
  logic [11:0] wh;
  logic [8:0]  wb;
  logic [11:0] bc;
  logic [13:0] raw;
  logic [9:0]  packed_sz;
  logic [12:0] full_sz;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             hit;
  logic             miss;
  logic             room;

  function automatic logic [BPP_W-1:0] eff_bpp(input logic [BPP_W-1:0] v);
    logic [BPP_W-1:0] r;
    if (v == 3'd0) r = 3'd1;
    else if (v > 3'd4) r = 3'd4;
    else r = v;
    return r;
  endfunction

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] r;
    if (v == '0) r = SIDE_W'(1);
    else if (v > SIDE_W'(MAX_TILE)) r = SIDE_W'(MAX_TILE);
    else r = v;
    return r;
  endfunction

  function automatic logic [PIX_W-1:0] mask_pixel(input logic [PIX_W-1:0] v,
                                                   input logic [BPP_W-1:0] b);
    logic [PIX_W-1:0] r;
    case (b)
      3'd1:    r = {24'd0, v[7:0]};
      3'd2:    r = {16'd0, v[15:0]};
      3'd3:    r = {8'd0, v[23:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  assign room = total < CNT_W'(PALETTE_DEPTH);
  assign hit  = cmd.search && cmp_vld && (ram_q == px);
  assign miss = cmd.search && cmp_vld && (ram_q != px) && (rd_cnt == total);

  assign ram_we    = (cmd.check && !in_tile) || (miss && room);
  assign ram_waddr = cmd.check ? '0 : total[IDX_W-1:0];

  tpa_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (px),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      bpp  <= eff_bpp(bpp_cfg);
      px   <= mask_pixel(pixel, eff_bpp(bpp_cfg));
      w    <= clamp_side(tile_width);
      h    <= clamp_side(tile_height);
      last <= last_pixel;
    end
    if (cmd.check) begin
      fresh   <= !in_tile;
      cmp_idx <= '0;
      if (!in_tile || overflowed) idx <= '0;
      else if (px == prev_px) idx <= prev_idx;
    end
    if (cmd.search) begin
      cmp_idx <= rd_cnt[IDX_W-1:0];
      if (hit) idx <= cmp_idx;
      if (miss) begin
        idx   <= room ? total[IDX_W-1:0] : '0;
        fresh <= room;
      end
    end
    if (cmd.math1) begin
      wh <= 12'(w) * 12'(h);
      wb <= 9'(({1'b0, w} + 7'd7) >> 3) * h;
      bc <= 12'(bpp) * 12'(total);
    end
    if (cmd.math2) begin
      raw       <= 14'(wh) * 14'(bpp);
      packed_sz <= 10'd2 + 10'({bpp, 1'b0}) + 10'(wb);
      full_sz   <= 13'd2 + 13'(bc) + 13'(wh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total       <= '0;
      prev_px     <= '0;
      prev_idx    <= '0;
      in_tile     <= 1'b0;
      overflowed  <= 1'b0;
      stream_pend <= 1'b1;
      rd_cnt      <= '0;
      cmp_vld     <= 1'b0;
    end else begin
      if (cmd.check) begin
        rd_cnt  <= '0;
        cmp_vld <= 1'b0;
        if (!in_tile) begin
          total      <= CNT_W'(1);
          overflowed <= 1'b0;
          prev_px    <= px;
          prev_idx   <= '0;
          in_tile    <= 1'b1;
        end
      end
      if (cmd.search) begin
        // one read issued per cycle, compared in the cycle after
        if (rd_cnt < total) begin
          rd_cnt  <= rd_cnt + CNT_W'(1);
          cmp_vld <= 1'b1;
        end else begin
          cmp_vld <= 1'b0;
        end
        if (hit) begin
          prev_px  <= px;
          prev_idx <= cmp_idx;
        end
        if (miss) begin
          prev_px <= px;
          if (room) begin
            prev_idx <= total[IDX_W-1:0];
            total    <= total + CNT_W'(1);
          end else begin
            prev_idx   <= '0;
            total      <= '0;
            overflowed <= 1'b1;
          end
        end
      end
      if (cmd.load && last) begin
        in_tile     <= 1'b0;
        overflowed  <= 1'b0;
        stream_pend <= 1'b0;
      end
    end
  end

  // mode choice from the registered estimates
  logic [13:0] best;
  logic [7:0]  ctl;
  logic [1:0]  filt;

  always_comb begin
    best = raw;
    ctl  = CTL_RAW;
    filt = FILTER_NONE;
    if (total == CNT_W'(1)) begin
      best = 14'(bpp);
      ctl  = CTL_SOLID;
    end else begin
      if (total == CNT_W'(2) && 14'(packed_sz) < raw) begin
        best = 14'(packed_sz);
        ctl  = CTL_PACKED;
        filt = FILTER_PALETTE;
      end
      if (bpp != 3'd1) begin
        if (total == '0) begin
          if (bpp == 3'd3 && w >= SIDE_W'(JPEG_MIN_SIDE) && h >= SIDE_W'(JPEG_MIN_SIDE)
              && best > 14'(JPEG_MIN_BYTES)) begin
            ctl  = CTL_JPEG;
            filt = FILTER_NONE;
          end
        end else if (14'(full_sz) < best) begin
          best = 14'(full_sz);
          ctl  = CTL_FULL_PALETTE;
          filt = FILTER_PALETTE;
        end
      end
    end
    if (stream_pend) ctl = ctl | CTL_STREAM_RESET;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pixel_index  <= idx;
      new_color    <= fresh;
      overflow     <= overflowed;
      tile_done    <= last;
      control_byte <= last ? ctl : 8'd0;
      filter_id    <= last ? filt : FILTER_NONE;
      color_count  <= last ? total : '0;
      est_size     <= last ? best : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign status.need_search = in_tile && !overflowed && (px != prev_px);
  assign status.hit         = hit;
  assign status.miss        = miss;
  assign status.last        = last;
  assign status.out_free    = !out_valid || out_ready;

  `TPA_ASSERT_IMP(a_total_range, 1'b1, total <= CNT_W'(PALETTE_DEPTH))
  `TPA_ASSERT_IMP(a_ovf_zero_count, overflowed, total == '0)
  `TPA_ASSERT_IMP(a_hit_miss_excl, hit, !miss)
  `TPA_ASSERT_IMP(a_new_not_ovf, out_valid && new_color, !overflow)
  `TPA_ASSERT_NXT(a_miss_grows, miss && room, total == $past(total) + CNT_W'(1))

endmodule

`default_nettype wire

// ----- rtl/tile_palette_analyzer.sv -----
// ----------------------------------------------------------------------------
// tile_palette_analyzer
// builds a first-seen colour palette per tile and picks the tight subencoding
// ----------------------------------------------------------------------------
// pixels of one tile enter in raster order on the in_valid/in_ready channel,
// with last_pixel set on the final one. every item gives one result on the
// out_valid/out_ready channel: its palette index and new-entry flag, and on
// the last pixel the control byte, filter code, colour count and size guess.
// an item passes the idle, check and out states; when it differs from the
// previous pixel, inside a tile that has not overflowed, a search state sits
// before out and reads the palette one entry per cycle through the palette
// ram read port until it hits or has missed every entry. the last pixel also
// passes the size math states math1 and math2. one item is worked at a time.
// the result sits in an output register, so the next item is taken while it
// waits; a stalled receiver holds the block only when a new result is ready.
// reset clears the tile state, sets bytes_per_pixel to 4 and arms the stream
// reset bits for the first finished tile; the palette ram needs no clearing.
// bytes_per_pixel sits at apb byte address 0 and may be written when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_palette_analyzer import tpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [2:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [PIX_W-1:0]  pixel,
  input  wire logic [SIDE_W-1:0] tile_width,
  input  wire logic [SIDE_W-1:0] tile_height,
  input  wire logic              last_pixel,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [IDX_W-1:0]       pixel_index,
  output logic                   new_color,
  output logic                   overflow,
  output logic                   tile_done,
  output logic [7:0]             control_byte,
  output logic [1:0]             filter_id,
  output logic [CNT_W-1:0]       color_count,
  output logic [EST_W-1:0]       est_size
);

  logic [BPP_W-1:0] bytes_per_pixel;
  tpa_cmd_t         cmd;
  tpa_status_t      status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= BPP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_BPP) begin
      bytes_per_pixel <= pwdata[BPP_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_BPP) ? {29'd0, bytes_per_pixel} : 32'd0;

  tpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tpa_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .bpp_cfg      (bytes_per_pixel),
    .pixel        (pixel),
    .tile_width   (tile_width),
    .tile_height  (tile_height),
    .last_pixel   (last_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .pixel_index  (pixel_index),
    .new_color    (new_color),
    .overflow     (overflow),
    .tile_done    (tile_done),
    .control_byte (control_byte),
    .filter_id    (filter_id),
    .color_count  (color_count),
    .est_size     (est_size)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: tile palette analyzer testbench
// streams tiles of pixels through the block with random idling on both sides
// and a long output hold, predicts palette index, overflow and subencoding
// choice per pixel in a local model, and checks every result in order
// ----------------------------------------------------------------------------
module tb_top import tpa_pkg::*; ();

  localparam logic [3:0] NO_WRITE = 4'hf;
  localparam int RANDOM_ITEMS = 1150;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_PRINTS = 40;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             fresh;
    logic             ovf;
    logic             done;
    logic [7:0]       ctl;
    logic [1:0]       filt;
    logic [CNT_W-1:0] count;
    logic [EST_W-1:0] est;
  } pix_result_t;

  typedef struct packed {
    logic [3:0]       set_bpp;
    logic [PIX_W-1:0] pix;
    logic [5:0]       w;
    logic [5:0]       h;
    bit               is_last;
    bit               typed;
    pix_result_t      res;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [PIX_W-1:0] pixel = '0;
  logic [SIDE_W-1:0] tile_width = '0;
  logic [SIDE_W-1:0] tile_height = '0;
  logic last_pixel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [IDX_W-1:0] pixel_index;
  logic new_color;
  logic overflow;
  logic tile_done;
  logic [7:0] control_byte;
  logic [1:0] filter_id;
  logic [CNT_W-1:0] color_count;
  logic [EST_W-1:0] est_size;

  tile_palette_analyzer u_dut (.*);

  always #4 clk = ~clk;

  // local copy of the analyzer state
  logic [31:0] seen_colors [PALETTE_DEPTH];
  int          colors_held = 0;
  logic [31:0] last_color = '0;
  logic [7:0]  last_index = '0;
  bit          tile_open = 1'b0;
  bit          tile_overflowed = 1'b0;
  bit          reset_bits_armed = 1'b1;
  logic [2:0]  pixel_bytes_reg = BPP_RESET;

  pix_result_t pending_pixel_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int tiles_done = 0;
  int tiles_overflowed = 0;
  int tiles_jpeg = 0;
  int tiles_full = 0;
  int tiles_packed = 0;
  int tiles_solid = 0;
  bit calm = 1'b0;
  bit backpressure_done = 1'b0;

  localparam plan_row_t PLAN [0:21] = '{
    '{NO_WRITE, 32'hffff_ffff, 6'd1, 6'd1, 1'b1, 1'b1,
      '{8'd0, 1'b1, 1'b0, 1'b1, CTL_SOLID | CTL_STREAM_RESET, FILTER_NONE, 9'd1, 14'd4}},
    '{NO_WRITE, 32'h0000_0000, 6'd48, 6'd48, 1'b1, 1'b1,
      '{8'd0, 1'b1, 1'b0, 1'b1, CTL_SOLID, FILTER_NONE, 9'd1, 14'd4}},
    '{NO_WRITE, 32'h1234_5678, 6'd0, 6'd0, 1'b0, 1'b1,
      '{8'd0, 1'b1, 1'b0, 1'b0, 8'h00, FILTER_NONE, 9'd0, 14'd0}},
    '{NO_WRITE, 32'h9abc_def0, 6'd0, 6'd0, 1'b0, 1'b1,
      '{8'd1, 1'b1, 1'b0, 1'b0, 8'h00, FILTER_NONE, 9'd0, 14'd0}},
    '{NO_WRITE, 32'h1234_5678, 6'd63, 6'd63, 1'b1, 1'b1,
      '{8'd0, 1'b0, 1'b0, 1'b1, CTL_PACKED, FILTER_PALETTE, 9'd2, 14'd298}},
    // one byte pixels, upper bytes must be ignored
    '{4'd1, 32'hffff_ff01, 6'd8, 6'd8, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h0000_0001, 6'd8, 6'd8, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h5a5a_5a02, 6'd8, 6'd8, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h0000_0101, 6'd8, 6'd8, 1'b1, 1'b0, '0},
    // zero bytes per pixel acts as one
    '{4'd0, 32'h0000_0000, 6'd16, 6'd16, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h0000_00ff, 6'd16, 6'd16, 1'b1, 1'b0, '0},
    // out-of-range size acts as four, palette search hits
    '{4'd7, 32'h1111_1111, 6'd40, 6'd40, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h2222_2222, 6'd40, 6'd40, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h3333_3333, 6'd40, 6'd40, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h2222_2222, 6'd40, 6'd40, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h1111_1111, 6'd40, 6'd40, 1'b1, 1'b0, '0},
    // register rewritten inside a tile
    '{4'd2, 32'haaaa_5555, 6'd5, 6'd3, 1'b0, 1'b0, '0},
    '{4'd3, 32'h00bb_5555, 6'd5, 6'd3, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'hcc00_5555, 6'd5, 6'd3, 1'b1, 1'b0, '0},
    '{4'd5, 32'h8000_0000, 6'd1, 6'd48, 1'b1, 1'b0, '0},
    '{4'd6, 32'h7fff_ffff, 6'd9, 6'd9, 1'b0, 1'b0, '0},
    '{NO_WRITE, 32'h7fff_fffe, 6'd9, 6'd9, 1'b1, 1'b0, '0}
  };

  function automatic logic [31:0] color_mask();
    case (pixel_bytes_reg)
      3'd0, 3'd1: return 32'h0000_00ff;
      3'd2: return 32'h0000_ffff;
      3'd3: return 32'h00ff_ffff;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic pix_result_t analyze_pixel(input logic [31:0] raw, input logic [5:0] w_in,
                                                input logic [5:0] h_in, input bit is_last);
    pix_result_t r;
    logic [31:0] px;
    int bpp, w, h, best, packed_sz, full_sz, i;
    bit found;
    r = '0;
    bpp = (pixel_bytes_reg == 3'd0) ? 1 : (pixel_bytes_reg > 3'd4) ? 4 : int'(pixel_bytes_reg);
    px = raw & color_mask();
    if (!tile_open) begin
      seen_colors[0] = px;
      colors_held = 1;
      tile_overflowed = 1'b0;
      last_color = px;
      last_index = 8'd0;
      tile_open = 1'b1;
      r.fresh = 1'b1;
    end else if (!tile_overflowed) begin
      if (px == last_color) begin
        r.index = last_index;
      end else begin
        found = 1'b0;
        for (i = 0; i < colors_held && !found; i++) begin
          if (seen_colors[i] == px) begin
            r.index = 8'(i);
            found = 1'b1;
          end
        end
        if (!found) begin
          if (colors_held < PALETTE_DEPTH) begin
            r.index = 8'(colors_held);
            seen_colors[colors_held] = px;
            colors_held++;
            r.fresh = 1'b1;
          end else begin
            // one color too many: the tile gives up on its palette
            tile_overflowed = 1'b1;
            colors_held = 0;
            r.index = 8'd0;
          end
        end
        last_color = px;
        last_index = r.index;
      end
    end
    r.ovf = tile_overflowed;
    if (is_last) begin
      w = (w_in == 6'd0) ? 1 : (w_in > 6'(MAX_TILE)) ? MAX_TILE : int'(w_in);
      h = (h_in == 6'd0) ? 1 : (h_in > 6'(MAX_TILE)) ? MAX_TILE : int'(h_in);
      r.done = 1'b1;
      r.count = 9'(colors_held);
      r.filt = FILTER_NONE;
      if (colors_held == 1) begin
        best = bpp;
        r.ctl = CTL_SOLID;
      end else begin
        best = w * h * bpp;
        r.ctl = CTL_RAW;
        if (colors_held == 2) begin
          packed_sz = 2 + 2 * bpp + ((w + 7) / 8) * h;
          if (packed_sz < best) begin
            best = packed_sz;
            r.ctl = CTL_PACKED;
            r.filt = FILTER_PALETTE;
          end
        end
        if (bpp != 1) begin
          if (colors_held == 0) begin
            if (bpp == 3 && w >= JPEG_MIN_SIDE && h >= JPEG_MIN_SIDE && best > JPEG_MIN_BYTES) begin
              r.ctl = CTL_JPEG;
              r.filt = FILTER_NONE;
            end
          end else begin
            full_sz = 2 + bpp * colors_held + w * h;
            if (full_sz < best) begin
              best = full_sz;
              r.ctl = CTL_FULL_PALETTE;
              r.filt = FILTER_PALETTE;
            end
          end
        end
      end
      if (reset_bits_armed) r.ctl = r.ctl | CTL_STREAM_RESET;
      reset_bits_armed = 1'b0;
      r.est = (best > 16383) ? 14'h3fff : 14'(best);
      tiles_done++;
      if (tile_overflowed) tiles_overflowed++;
      if ((r.ctl & 8'hf0) == CTL_JPEG) tiles_jpeg++;
      if ((r.ctl & 8'hf0) == CTL_FULL_PALETTE) tiles_full++;
      if ((r.ctl & 8'hf0) == CTL_PACKED) tiles_packed++;
      if ((r.ctl & 8'hf0) == CTL_SOLID) tiles_solid++;
      tile_open = 1'b0;
      tile_overflowed = 1'b0;
    end
    return r;
  endfunction

  task automatic send_pixel(input logic [31:0] pix, input logic [5:0] w, input logic [5:0] h,
                            input bit is_last, input bit typed, input pix_result_t typed_res);
    pix_result_t r;
    bit ignored;
    if (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 33);
    end
    in_valid <= 1'b1;
    pixel <= pix;
    tile_width <= w;
    tile_height <= h;
    last_pixel <= is_last;
    do @(posedge clk); while (!in_ready);
    ignored = tile_open && tile_overflowed;
    r = analyze_pixel(pix, w, h, is_last);
    pending_pixel_results.push_back(typed ? typed_res : r);
    if (!ignored) items_sent++;
    calm = items_sent >= 400 && items_sent < 600;
  endtask

  // register writes only once every pending result is out
  task automatic write_bpp(input logic [2:0] v);
    in_valid <= 1'b0;
    while (pending_pixel_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * int'(REG_BPP));
    pwdata <= ($urandom() & 32'hffff_fff8) | 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    pixel_bytes_reg = v;
  endtask

  task automatic small_tile();
    logic [31:0] cols [40];
    logic [31:0] pix;
    int k, len, i, w, h, cut, shape;
    shape = $urandom_range(0, 9);
    k = (shape < 2) ? 1 : (shape < 5) ? 2 : (shape < 7) ? $urandom_range(3, 6)
                                                        : $urandom_range(7, 40);
    len = $urandom_range(1, k + 14);
    w = $urandom_range(0, 63);
    h = $urandom_range(0, 63);
    if ($urandom_range(0, 3) == 0) w = $urandom_range(0, 9);
    for (i = 0; i < k; i++) cols[i] = $urandom();
    cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, len) : 0;
    pix = cols[0];
    for (i = 0; i < len; i++) begin
      if (cut != 0 && i == cut) write_bpp(3'($urandom_range(0, 7)));
      if (i == 0 || $urandom_range(0, 9) >= 4) pix = cols[$urandom_range(0, k - 1)];
      // junk above the pixel size must not change the color
      pix = pix ^ ($urandom() & ~color_mask());
      send_pixel(pix, 6'(w), 6'(h), i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic big_tile(input int ncol, input int w, input int h);
    logic [31:0] cols [PALETTE_DEPTH + 1];
    logic [31:0] salt;
    int i, pick, strays;
    salt = $urandom();
    for (i = 0; i < ncol; i++) begin
      cols[i] = $urandom();
      cols[i][15:0] = 16'(i) ^ salt[15:0];
      send_pixel(cols[i], 6'(w), 6'(h), 1'b0, 1'b0, '0);
      pick = $urandom_range(0, 9);
      if (pick < 2)
        send_pixel(cols[i] ^ ($urandom() & ~color_mask()), 6'(w), 6'(h), 1'b0, 1'b0, '0);
      else if (pick == 2)
        send_pixel(cols[$urandom_range(0, i)], 6'(w), 6'(h), 1'b0, 1'b0, '0);
    end
    // past overflow the block ignores pixels up to the last one
    strays = (ncol > PALETTE_DEPTH) ? $urandom_range(0, 6) : 0;
    for (i = 0; i < strays; i++) send_pixel($urandom(), 6'(w), 6'(h), 1'b0, 1'b0, '0);
    send_pixel(cols[$urandom_range(0, ncol - 1)], 6'(w), 6'(h), 1'b1, 1'b0, '0);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    pix_result_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_pixel_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_PRINTS)
          $display("%0t: result with no pixel pending, expected none, actual index %0d",
                   $time, pixel_index);
      end else begin
        want = pending_pixel_results.pop_front();
        check_field("pixel_index", int'(want.index), int'(pixel_index));
        check_field("new_color", int'(want.fresh), int'(new_color));
        check_field("overflow", int'(want.ovf), int'(overflow));
        check_field("tile_done", int'(want.done), int'(tile_done));
        check_field("control_byte", int'(want.ctl), int'(control_byte));
        check_field("filter_id", int'(want.filt), int'(filter_id));
        check_field("color_count", int'(want.count), int'(color_count));
        check_field("est_size", int'(want.est), int'(est_size));
      end
    end
  end

  // receiver: random stalls, plus one long hold so the block backs up
  initial begin
    @(posedge clk);
    forever begin
      if (!rst && !backpressure_done && results_seen >= 120) begin
        backpressure_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 33;
        @(posedge clk);
      end
    end
  end

  initial begin
    int n, tile_no;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (n = 0; n < 22; n++) begin
      if (PLAN[n].set_bpp != NO_WRITE) write_bpp(PLAN[n].set_bpp[2:0]);
      send_pixel(PLAN[n].pix, PLAN[n].w, PLAN[n].h, PLAN[n].is_last, PLAN[n].typed,
                 PLAN[n].res);
    end

    tile_no = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tile_no++;
      if (tile_no == 6) begin
        // overflowed three byte tile large enough for jpeg
        write_bpp(3'd3);
        big_tile(PALETTE_DEPTH + 1, 32, 32);
      end else if (tile_no == 20) begin
        write_bpp(3'($urandom_range(1, 4)));
        big_tile(PALETTE_DEPTH, $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (tile_no == 35) begin
        write_bpp(3'($urandom_range(2, 7)));
        big_tile(PALETTE_DEPTH + 1, $urandom_range(0, 63), $urandom_range(0, 63));
      end else begin
        if ($urandom_range(0, 9) < 3) write_bpp(3'($urandom_range(0, 7)));
        small_tile();
      end
    end

    in_valid <= 1'b0;
    while (pending_pixel_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("run covered %0d pixels in %0d tiles, %0d of them overflowed", items_sent,
             tiles_done, tiles_overflowed);
    $display("modes seen: %0d solid, %0d packed, %0d full palette, %0d jpeg", tiles_solid,
             tiles_packed, tiles_full, tiles_jpeg);
    if (mismatches == 0 && pending_pixel_results.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #16_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- tile_palette_analyzer.f -----
+incdir+rtl
rtl/tpa_pkg.sv
rtl/tpa_ram.sv
rtl/tpa_ctrl.sv
rtl/tpa_datapath.sv
rtl/tile_palette_analyzer.sv
tb/tb_top.sv
